FILE: design/assert_macros.svh
// Assertion macros used by the barometer compensation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define BC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/bc_pkg.sv
// Types, constants and helpers for the barometer compensation pipeline.
package bc_pkg;

	localparam int unsigned DW          = 64;
	localparam int unsigned DIV_STAGES  = DW;
	localparam int unsigned PIPE_DEPTH  = 85;
	localparam int unsigned SIDE_LEN    = 80;
	localparam int unsigned INV_LEN     = 5;

	localparam logic [63:0] T_OFFSET    = 64'd128000;
	localparam logic [63:0] PRESS_BASE  = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [63:0] PRESS_BIAS  = 64'd1 << 47;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [23:0] temperature_centi;
		logic        [31:0] pressure_q24_8;
		logic               pressure_invalid;
	} result_t;

	typedef struct packed {
		logic neg;
		logic inv;
	} div_tag_t;

	typedef struct packed {
		logic signed [31:0] fine;
		logic signed [23:0] tc;
		logic        [19:0] ap;
	} side_t;

	function automatic logic [63:0] sx16(logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

	function automatic logic [63:0] sar64(logic [63:0] x, int unsigned n);
		logic signed [63:0] xs;
		xs = x;
		return xs >>> n;
	endfunction

endpackage

FILE: design/barometer_compensation_core.sv
// The pipeline has 85 register stages from sample transfer to result valid.
// Throughput: one sample per cycle while the result is not stalled; the 64-stage divider sets the depth.
// A stalled result freezes every stage together, nothing is dropped.
// Reset clears all valid bits and the four coefficient registers to zero.
// Coefficients are read live by each stage; write them only while idle.
`include "assert_macros.svh"
module barometer_compensation_core import bc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic [47:0] temp_coeffs_q, press_a_q, press_b_q, press_c_q;
	logic [PIPE_DEPTH:1] vld_q;
	logic adv;

	logic [15:0] t1, p1;
	logic signed [15:0] t2, t3;
	logic [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_coeffs_q[15:0];
	assign t2 = temp_coeffs_q[31:16];
	assign t3 = temp_coeffs_q[47:32];
	assign p1 = press_a_q[15:0];
	assign p2 = press_a_q[31:16];
	assign p3 = press_a_q[47:32];
	assign p4 = press_b_q[15:0];
	assign p5 = press_b_q[31:16];
	assign p6 = press_b_q[47:32];
	assign p7 = press_c_q[15:0];
	assign p8 = press_c_q[31:16];
	assign p9 = press_c_q[47:32];

	assign adv          = !vld_q[PIPE_DEPTH] || result_ready;
	assign sample_ready = adv;
	assign result_valid = vld_q[PIPE_DEPTH];
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_c_q     <= '0;
			vld_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_TEMP:    temp_coeffs_q <= cfg_data;
					REG_PRESS_A: press_a_q     <= cfg_data;
					REG_PRESS_B: press_b_q     <= cfg_data;
					REG_PRESS_C: press_c_q     <= cfg_data;
					default: ;
				endcase
			end
			if (adv) begin
				vld_q <= {vld_q[PIPE_DEPTH-1:1], sample_valid};
			end
		end
	end

	// ---------------- temperature ----------------
	logic [19:0] at_s1, ap_s1, ap_s2, ap_s3, ap_s4;
	logic signed [17:0] d1;
	logic signed [16:0] d2;
	logic signed [33:0] m1, m2, m1_s2, m2_s2;
	logic signed [22:0] v1_s3;
	logic signed [21:0] m2_sh;
	logic signed [37:0] m3, m3_s3;
	logic signed [23:0] m3_hi;
	logic signed [31:0] fine_s4;
	logic signed [34:0] tc_wide;
	logic signed [26:0] tc_sh;
	logic signed [23:0] tc_sat;

	assign d1    = $signed({1'b0, at_s1[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d2    = $signed({1'b0, at_s1[19:4]}) - $signed({1'b0, t1});
	assign m1    = d1 * t2;
	assign m2    = d2 * d2;
	assign m2_sh = m2_s2[33:12];
	assign m3    = m2_sh * t3;
	assign m3_hi = m3_s3[37:14];

	assign tc_wide = (35'(fine_s4) <<< 2) + 35'(fine_s4) + 35'sd128;
	assign tc_sh   = tc_wide[34:8];

	always_comb begin
		if (tc_sh > 27'sd8388607) begin
			tc_sat = 24'sh7FFFFF;
		end else if (tc_sh < -27'sd8388608) begin
			tc_sat = 24'sh800000;
		end else begin
			tc_sat = tc_sh[23:0];
		end
	end

	// ---------------- pressure ----------------
	logic [63:0] a_s5;
	side_t       side_q [SIDE_LEN];
	logic [63:0] aa_p, ap5_p, ap2_p, aap6_p, aap3_p;
	logic [63:0] ap5_s8, ap5_s9, ap2_s8, ap2_s9;
	logic [63:0] b_s10, a2_s10;
	logic [63:0] pn, a3_p, nn_p;
	logic [63:0] d_s13, n_s13;
	logic [63:0] ma_s14, mb_s14;
	div_tag_t    tag_s14, tag_div;
	logic [63:0] quo;
	logic [63:0] p_s79;
	logic        inv_s79;
	logic        inv_q [INV_LEN];
	logic [63:0] qq_s80, qq_s81, pv_s80, pv_s81, pv_s82, pv_s83;
	logic [63:0] p9q_p, p8p_p, c1_p, p8p_s82, p8p_s83;
	logic [63:0] sum_s84, fin;
	logic [31:0] press_clamped;

	assign pn = PRESS_BASE - 64'(side_q[5].ap);

	bc_mul64 u_mul_aa   (.clk, .en(adv), .a(a_s5), .b(a_s5),     .p(aa_p));
	bc_mul64 u_mul_ap5  (.clk, .en(adv), .a(a_s5), .b(sx16(p5)), .p(ap5_p));
	bc_mul64 u_mul_ap2  (.clk, .en(adv), .a(a_s5), .b(sx16(p2)), .p(ap2_p));
	bc_mul64 u_mul_aap6 (.clk, .en(adv), .a(aa_p), .b(sx16(p6)), .p(aap6_p));
	bc_mul64 u_mul_aap3 (.clk, .en(adv), .a(aa_p), .b(sx16(p3)), .p(aap3_p));
	bc_mul64 u_mul_a3 (
		.clk, .en(adv), .a(a2_s10 + PRESS_BIAS), .b({48'd0, p1}), .p(a3_p)
	);
	bc_mul64 u_mul_nn (
		.clk, .en(adv), .a((pn << 31) - b_s10), .b(PRESS_SCALE), .p(nn_p)
	);

	bc_div u_div (
		.clk,
		.en       (adv),
		.dividend (ma_s14),
		.divisor  (mb_s14),
		.tag      (tag_s14),
		.quotient (quo),
		.tag_out  (tag_div)
	);

	bc_mul64 u_mul_p9q (.clk, .en(adv), .a(sar64(p_s79, 13)), .b(sx16(p9)), .p(p9q_p));
	bc_mul64 u_mul_p8p (.clk, .en(adv), .a(p_s79), .b(sx16(p8)), .p(p8p_p));
	bc_mul64 u_mul_c1  (.clk, .en(adv), .a(p9q_p), .b(qq_s81), .p(c1_p));

	assign fin = sar64(sum_s84, 8) + (sx16(p7) << 4);

	always_comb begin
		if (fin[63]) begin
			press_clamped = '0;
		end else if (fin[63:32] != '0) begin
			press_clamped = '1;
		end else begin
			press_clamped = fin[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			at_s1   <= sample.raw_temperature;
			ap_s1   <= sample.raw_pressure;
			m1_s2   <= m1;
			m2_s2   <= m2;
			ap_s2   <= ap_s1;
			v1_s3   <= m1_s2[33:11];
			m3_s3   <= m3;
			ap_s3   <= ap_s2;
			fine_s4 <= 32'(v1_s3) + 32'(m3_hi);
			ap_s4   <= ap_s3;

			a_s5      <= 64'(fine_s4) - T_OFFSET;
			side_q[0] <= '{fine: fine_s4, tc: tc_sat, ap: ap_s4};
			for (int k = 1; k < SIDE_LEN; k++) begin
				side_q[k] <= side_q[k-1];
			end

			ap5_s8 <= ap5_p;
			ap5_s9 <= ap5_s8;
			ap2_s8 <= ap2_p;
			ap2_s9 <= ap2_s8;
			b_s10  <= aap6_p + (ap5_s9 << 17) + (sx16(p4) << 35);
			a2_s10 <= sar64(aap3_p, 8) + (ap2_s9 << 12);

			d_s13 <= sar64(a3_p, 33);
			n_s13 <= nn_p;

			// divide magnitudes, restore the sign after the divider
			ma_s14  <= n_s13[63] ? -n_s13 : n_s13;
			mb_s14  <= d_s13[63] ? -d_s13 : d_s13;
			tag_s14 <= '{neg: n_s13[63] ^ d_s13[63], inv: d_s13 == '0};

			p_s79   <= tag_div.neg ? -quo : quo;
			inv_s79 <= tag_div.inv;
			inv_q[0] <= inv_s79;
			for (int k = 1; k < INV_LEN; k++) begin
				inv_q[k] <= inv_q[k-1];
			end

			qq_s80  <= sar64(p_s79, 13);
			qq_s81  <= qq_s80;
			pv_s80  <= p_s79;
			pv_s81  <= pv_s80;
			pv_s82  <= pv_s81;
			pv_s83  <= pv_s82;
			p8p_s82 <= p8p_p;
			p8p_s83 <= p8p_s82;

			sum_s84 <= pv_s83 + sar64(c1_p, 25) + sar64(p8p_s83, 19);

			result.fine_temperature  <= side_q[SIDE_LEN-1].fine;
			result.temperature_centi <= side_q[SIDE_LEN-1].tc;
			result.pressure_q24_8    <= inv_q[INV_LEN-1] ? '0 : press_clamped;
			result.pressure_invalid  <= inv_q[INV_LEN-1];
		end
	end

	`BC_ASSERT_IMPL(a_inv_zero, clk, arst_n, result_valid && result.pressure_invalid, result.pressure_q24_8 == '0)
	`BC_ASSERT_IMPL(a_fine_range, clk, arst_n, result_valid, ($countones(result.fine_temperature[31:23]) == 0) || ($countones(result.fine_temperature[31:23]) == 9))
	`BC_ASSERT_NEXT(a_stall_hold, clk, arst_n, !adv, $stable(vld_q))

endmodule

FILE: design/bc_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
module bc_mul64 import bc_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic [DW-1:0] p
);

	logic [63:0] ll, lh, hl;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1, hl_s1;

	assign ll = a[31:0] * b[31:0];
	assign lh = a[31:0] * b[63:32];
	assign hl = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll;
			lh_s1 <= lh[31:0];
			hl_s1 <= hl[31:0];
			p     <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

endmodule

FILE: design/bc_div.sv
// Pipelined restoring divider on 64-bit magnitudes, one quotient bit per stage.
module bc_div import bc_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  div_tag_t      tag,
	output logic [DW-1:0] quotient,
	output div_tag_t      tag_out
);

	logic [DW-1:0] rem_q [DIV_STAGES];
	logic [DW-1:0] nq_q  [DIV_STAGES];
	logic [DW-1:0] dv_q  [DIV_STAGES];
	div_tag_t      tag_q [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [DW-1:0] rem_in, nq_in, dv_in;
		div_tag_t      tag_in;
		logic [DW:0]   trial, diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = dividend;
			assign dv_in  = divisor;
			assign tag_in = tag;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign nq_in  = nq_q[i-1];
			assign dv_in  = dv_q[i-1];
			assign tag_in = tag_q[i-1];
		end

		// shift in the next dividend bit, keep the quotient in its vacated lsb
		assign trial = {rem_in, nq_in[DW-1]};
		assign diff  = trial - {1'b0, dv_in};
		assign ge    = trial >= {1'b0, dv_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nq_q[i]  <= {nq_in[DW-2:0], ge};
				dv_q[i]  <= dv_in;
				tag_q[i] <= tag_in;
			end
		end
	end

	assign quotient = nq_q[DIV_STAGES-1];
	assign tag_out  = tag_q[DIV_STAGES-1];

endmodule

FILE: verif/barometer_compensation_core_tb.sv
// Self-checking testbench for the barometer compensation pipeline.
`timescale 1ns / 1ps
module barometer_compensation_core_tb;
	import bc_pkg::*;

	localparam int LATENCY     = 85;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_ready;
	sample_t     sample;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;

	barometer_compensation_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the coefficient registers
	logic [47:0] coef_temp, coef_pa, coef_pb, coef_pc;

	sample_t pending_samples[$];
	result_t expected_results[$];
	int      send_idle_pct;
	int      recv_stall_pct;
	int      error_count;
	int      quiet_cycles;
	bit      timed_out;
	bit      in_xfer;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] ext_s16(logic [47:0] r, int pos);
		logic signed [15:0] v;
		v = r[pos +: 16];
		return 64'(v);
	endfunction

	function automatic logic [63:0] shr_arith(logic [63:0] x, int n);
		logic signed [63:0] s;
		s = x;
		return s >>> n;
	endfunction

	function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q  = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic result_t compensate(sample_t s);
		result_t r;
		logic [63:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] d1, v1, d2, v2, fine, tc, a, b, p, q, c1, c2;
		logic signed [63:0] tcs;
		at = 64'(s.raw_temperature);
		ap = 64'(s.raw_pressure);
		t1 = 64'(coef_temp[15:0]);
		t2 = ext_s16(coef_temp, 16);
		t3 = ext_s16(coef_temp, 32);
		p1 = 64'(coef_pa[15:0]);
		p2 = ext_s16(coef_pa, 16);
		p3 = ext_s16(coef_pa, 32);
		p4 = ext_s16(coef_pb, 0);
		p5 = ext_s16(coef_pb, 16);
		p6 = ext_s16(coef_pb, 32);
		p7 = ext_s16(coef_pc, 0);
		p8 = ext_s16(coef_pc, 16);
		p9 = ext_s16(coef_pc, 32);
		d1 = (at >> 3) - (t1 << 1);
		v1 = shr_arith(d1 * t2, 11);
		d2 = (at >> 4) - t1;
		v2 = shr_arith(shr_arith(d2 * d2, 12) * t3, 14);
		fine = v1 + v2;
		tc = shr_arith(fine * 64'd5 + 64'd128, 8);
		tcs = tc;
		if (tcs > 64'sd8388607) tcs = 64'sd8388607;
		if (tcs < -64'sd8388608) tcs = -64'sd8388608;
		a = fine - 64'd128000;
		b = a * a * p6;
		b = b + ((a * p5) << 17);
		b = b + (p4 << 35);
		a = shr_arith(a * a * p3, 8) + ((a * p2) << 12);
		a = shr_arith(((64'd1 << 47) + a) * p1, 33);
		r.fine_temperature  = fine[31:0];
		r.temperature_centi = tcs[23:0];
		if (a == 64'd0) begin
			r.pressure_q24_8    = '0;
			r.pressure_invalid  = 1'b1;
		end else begin
			p  = 64'd1048576 - ap;
			p  = div_trunc(((p << 31) - b) * 64'd3125, a);
			q  = shr_arith(p, 13);
			c1 = shr_arith(p9 * q * q, 25);
			c2 = shr_arith(p8 * p, 19);
			p  = shr_arith(p + c1 + c2, 8) + (p7 << 4);
			r.pressure_invalid = 1'b0;
			if (p[63])
				r.pressure_q24_8 = '0;
			else if (p > 64'hFFFF_FFFF)
				r.pressure_q24_8 = 32'hFFFF_FFFF;
			else
				r.pressure_q24_8 = p[31:0];
		end
		return r;
	endfunction

	// driver: presents queued samples, random idle per phase
	always @(negedge clk) begin
		if (arst_n) begin
			if (sample_valid && !in_xfer) begin
				sample_valid <= 1'b1;
			end else if (pending_samples.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				sample_valid <= 1'b1;
				sample       <= pending_samples[0];
			end else begin
				sample_valid <= 1'b0;
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_xfer <= sample_valid && sample_ready;
			if (sample_valid && sample_ready) begin
				expected_results.push_back(compensate(sample));
				void'(pending_samples.pop_front());
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $realtime, result);
					error_count++;
				end else begin
					result_t e;
					e = expected_results.pop_front();
					if (result.fine_temperature !== e.fine_temperature)
						$display("%0t: fine_temperature expected %0d actual %0d", $realtime,
							e.fine_temperature, result.fine_temperature);
					if (result.temperature_centi !== e.temperature_centi)
						$display("%0t: temperature_centi expected %0d actual %0d", $realtime,
							e.temperature_centi, result.temperature_centi);
					if (result.pressure_q24_8 !== e.pressure_q24_8)
						$display("%0t: pressure_q24_8 expected %0d actual %0d", $realtime,
							e.pressure_q24_8, result.pressure_q24_8);
					if (result.pressure_invalid !== e.pressure_invalid)
						$display("%0t: pressure_invalid expected %0d actual %0d", $realtime,
							e.pressure_invalid, result.pressure_invalid);
					if (result !== e)
						error_count++;
				end
			end
			if ((sample_valid && sample_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
				timed_out = 1'b1;
				$display("barometer_compensation_core verification failed");
				$finish;
			end
		end
	end

	task automatic write_coef(cfg_reg_t idx, logic [47:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TEMP:    coef_temp = value;
			REG_PRESS_A: coef_pa   = value;
			REG_PRESS_B: coef_pb   = value;
			REG_PRESS_C: coef_pc   = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [19:0] raw_value();
		case ($urandom_range(5))
			0: return '0;
			1: return 20'hFFFFF;
			default: return 20'($urandom);
		endcase
	endfunction

	// calibration by flavor: 0 typical with random perturbation, 1 to 3 extreme values, any other random
	task automatic load_coefs(int flavor);
		logic [15:0] w[12];
		for (int k = 0; k < 12; k++) w[k] = 16'($urandom);
		if (flavor == 0) begin
			w[0] = 16'd27504 + 16'($urandom_range(2000)); w[1] = 16'd26435;
			w[2] = 16'hFC18;  w[3] = 16'd36477 + 16'($urandom_range(2000));
			w[4] = 16'hD6D0;  w[5] = 16'd3024;  w[6] = 16'd2855;
			w[7] = 16'd140;   w[8] = 16'hFFF9;  w[9] = 16'd15500;
			w[10] = 16'hD408; w[11] = 16'd6000;
		end else if (flavor == 1) begin
			for (int k = 0; k < 12; k++) w[k] = 16'hFFFF;
		end else if (flavor == 2) begin
			for (int k = 0; k < 12; k++) w[k] = (k == 0 || k == 3) ? 16'hFFFF : 16'h8000;
		end else if (flavor == 3) begin
			for (int k = 0; k < 12; k++) w[k] = 16'h7FFF;
		end
		write_coef(REG_TEMP,    {w[2], w[1], w[0]});
		write_coef(REG_PRESS_A, {w[5], w[4], w[3]});
		write_coef(REG_PRESS_B, {w[8], w[7], w[6]});
		write_coef(REG_PRESS_C, {w[11], w[10], w[9]});
	endtask

	task automatic run_phase(int n, int idle, int stall);
		sample_t s;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < n; k++) begin
			s.raw_temperature = raw_value();
			s.raw_pressure    = raw_value();
			pending_samples.push_back(s);
		end
		wait_drained();
	endtask

	initial begin
		sample_t s;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		result_ready = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_TEMP;
		cfg_data     = '0;
		coef_temp = '0; coef_pa = '0; coef_pb = '0; coef_pc = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count = 0;
		quiet_cycles = 0;
		timed_out = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero coefficients: divisor zero, pressure flagged invalid
		s = '{raw_temperature: 20'h00000, raw_pressure: 20'hFFFFF};
		pending_samples.push_back(s);
		s = '{raw_temperature: 20'hFFFFF, raw_pressure: 20'h00000};
		pending_samples.push_back(s);
		wait_drained();

		// field extremes and one mid-range sample under the typical and each extreme calibration
		for (int f = 0; f < 4; f++) begin
			load_coefs(f);
			for (int k = 0; k < 4; k++) begin
				s.raw_temperature = k[0] ? 20'hFFFFF : 20'h00000;
				s.raw_pressure    = k[1] ? 20'hFFFFF : 20'h00000;
				pending_samples.push_back(s);
			end
			s = '{raw_temperature: 20'h80000, raw_pressure: 20'h65A00};
			pending_samples.push_back(s);
			wait_drained();
		end

		// random phases, calibration changed between them
		load_coefs(0);
		run_phase(250, 0, 0);
		load_coefs(4);
		run_phase(200, 73, 0);
		load_coefs(0);
		run_phase(200, 0, 73);
		load_coefs(4);
		run_phase(150, 7, 7);
		load_coefs(0);
		run_phase(200, 0, 0);
		load_coefs(1);
		run_phase(100, 30, 30);
		load_coefs(4);
		run_phase(180, 0, 50);

		if (error_count == 0) begin
			$display("barometer_compensation_core verification clean");
		end else begin
			$display("barometer_compensation_core verification failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/bc_pkg.sv
design/bc_mul64.sv
design/bc_div.sv
design/barometer_compensation_core.sv
verif/barometer_compensation_core_tb.sv
